### rtl/obb_obb_separating_axis_test_unit_macros.svh
// Assertion macros used by the box overlap test unit checker
`ifndef OBB_OBB_SEPARATING_AXIS_TEST_UNIT_MACROS_SVH
`define OBB_OBB_SEPARATING_AXIS_TEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define OBBSAT_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define OBBSAT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/obbsat_pkg.sv
// Types and constants of the box overlap test unit
package obbsat_pkg;

	// component slot and fixed point scales
	localparam int CW       = 16;
	localparam int AXIS_SH  = 14;
	localparam int P_W      = 2 * CW;
	localparam int M_W      = P_W + 3;
	localparam int V_W      = P_W + 1;
	localparam int L_W      = 2 * P_W;
	localparam int S_W      = P_W;
	localparam int SQ_REM_W = S_W + 2;
	localparam int Q_W      = AXIS_SH + 1;
	localparam int NUM_W    = S_W + AXIS_SH;
	localparam int LANE_LAT = 2 + S_W + Q_W + 1;
	localparam int N_AX     = 15;
	localparam int N_LEAF   = 16;

	// depth arithmetic widths
	localparam int DC_W    = CW + 1;
	localparam int PD_W    = DC_W + CW;
	localparam int DOT_W   = P_W + 2;
	localparam int AD_W    = DOT_W - 1;
	localparam int DIST_W  = PD_W + 2;
	localparam int ADIST_W = DIST_W - 1;
	localparam int RP_W    = AD_W + CW;
	localparam int DQ_W    = ADIST_W + AXIS_SH;
	localparam int DEP_W   = RP_W + 5;
	localparam int DQO_W   = DEP_W - 28;

	// port layout
	localparam int CEN_W     = 3 * CW;
	localparam int HALF_W    = 3 * CW;
	localparam int ORI_W     = 4 * CW;
	localparam int A_CEN_LSB = 0;
	localparam int A_HLF_LSB = A_CEN_LSB + CEN_W;
	localparam int A_ORI_LSB = A_HLF_LSB + HALF_W;
	localparam int B_CEN_LSB = A_ORI_LSB + ORI_W;
	localparam int B_HLF_LSB = B_CEN_LSB + CEN_W;
	localparam int B_ORI_LSB = B_HLF_LSB + HALF_W;
	localparam int IN_W      = B_ORI_LSB + ORI_W;
	localparam int AXO_W     = 3 * CW;
	localparam int DEPO_W    = 24;
	localparam int OUT_W     = AXO_W + DEPO_W;

	localparam logic [L_W-1:0]    DEGEN_LIMIT = 64'd720575940;
	localparam logic [DEPO_W-1:0] DEPTH_MAX   = 24'hFFFFFF;

	typedef logic signed [CW-1:0] scomp_t;
	typedef scomp_t axes_t [3][3];

	typedef struct packed {
		logic signed [P_W-1:0] xx;
		logic signed [P_W-1:0] yy;
		logic signed [P_W-1:0] zz;
		logic signed [P_W-1:0] xy;
		logic signed [P_W-1:0] xz;
		logic signed [P_W-1:0] yz;
		logic signed [P_W-1:0] wx;
		logic signed [P_W-1:0] wy;
		logic signed [P_W-1:0] wz;
	} qprod_t;

	typedef struct {
		axes_t                  ax_a;
		axes_t                  ax_b;
		logic signed [DC_W-1:0] dc [3];
		logic [CW-1:0]          ha [3];
		logic [CW-1:0]          hb [3];
	} box_pair_t;

	typedef struct packed {
		logic                   have;
		logic                   sep;
		logic [DEP_W-1:0]       depth;
		logic [AXO_W-1:0]       n;
	} cand_t;

endpackage

### rtl/obbsat_norm.sv
// Axis normalization lane: squared length, pipelined square root and division
module obbsat_norm
	import obbsat_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [V_W-1:0] v [3],
	output scomp_t                n [3],
	output logic                  skip
);

	logic [S_W-1:0] av [3];
	logic [L_W-1:0] sq_s1 [3];
	logic [S_W-1:0] av_s1 [3];
	logic [2:0]     neg_s1;
	logic [L_W-1:0] len2_sum;
	logic [L_W-1:0] len2_s2;
	logic [S_W-1:0] av_s2 [3];
	logic [2:0]     neg_s2;
	logic           skip_s2;

	logic [L_W-1:0]      sqx_q    [S_W];
	logic [SQ_REM_W-1:0] sqrem_q  [S_W];
	logic [S_W-1:0]      sqroot_q [S_W];
	logic [S_W-1:0]      sqav_q   [S_W][3];
	logic [2:0]          sqneg_q  [S_W];
	logic [S_W-1:0]      sqskip_q;

	logic [NUM_W-1:0] dvrem_q  [Q_W][3];
	logic [Q_W-1:0]   dvq_q    [Q_W][3];
	logic [S_W-1:0]   dvs_q    [Q_W];
	logic [2:0]       dvneg_q  [Q_W];
	logic [Q_W-1:0]   dvskip_q;

	scomp_t n_q [3];
	logic   skip_q;

	// magnitudes of the candidate components
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			av[i] = v[i][V_W-1] ? S_W'(-v[i]) : S_W'(v[i]);
		end
	end

	// square each component
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]  <= av[i] * av[i];
				av_s1[i]  <= av[i];
				neg_s1[i] <= v[i][V_W-1];
			end
		end
	end

	// squared length and degenerate check
	assign len2_sum = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s2 <= len2_sum;
			skip_s2 <= (len2_sum < DEGEN_LIMIT);
			av_s2   <= av_s1;
			neg_s2  <= neg_s1;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < S_W; k++) begin : g_sqrt
		logic [L_W-1:0]      x_in;
		logic [SQ_REM_W-1:0] rem_in;
		logic [S_W-1:0]      root_in;
		logic [S_W-1:0]      av_in [3];
		logic [2:0]          neg_in;
		logic                skip_in;
		logic [SQ_REM_W-1:0] rem_sh;
		logic [SQ_REM_W-1:0] trial;
		logic                ge;

		if (k == 0) begin : g_head
			assign x_in    = len2_s2;
			assign rem_in  = '0;
			assign root_in = '0;
			assign av_in   = av_s2;
			assign neg_in  = neg_s2;
			assign skip_in = skip_s2;
		end else begin : g_body
			assign x_in    = sqx_q[k-1];
			assign rem_in  = sqrem_q[k-1];
			assign root_in = sqroot_q[k-1];
			assign av_in   = sqav_q[k-1];
			assign neg_in  = sqneg_q[k-1];
			assign skip_in = sqskip_q[k-1];
		end

		assign rem_sh = {rem_in[SQ_REM_W-3:0], x_in[2*(S_W-1-k)+1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sqx_q[k]    <= x_in;
				sqrem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
				sqroot_q[k] <= {root_in[S_W-2:0], ge};
				sqav_q[k]   <= av_in;
				sqneg_q[k]  <= neg_in;
				sqskip_q[k] <= skip_in;
			end
		end
	end

	// restoring division |v| * 2^14 / s, one quotient bit per stage
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [NUM_W-1:0] rem_in [3];
		logic [Q_W-1:0]   q_in   [3];
		logic [S_W-1:0]   s_in;
		logic [2:0]       neg_in;
		logic             skip_in;
		logic [NUM_W-1:0] den;

		if (j == 0) begin : g_head
			for (genvar i = 0; i < 3; i++) begin : g_num
				assign rem_in[i] = {sqav_q[S_W-1][i], {AXIS_SH{1'b0}}}
					+ NUM_W'(sqroot_q[S_W-1] >> 1);
				assign q_in[i]   = '0;
			end
			assign s_in    = sqroot_q[S_W-1];
			assign neg_in  = sqneg_q[S_W-1];
			assign skip_in = sqskip_q[S_W-1];
		end else begin : g_body
			assign rem_in  = dvrem_q[j-1];
			assign q_in    = dvq_q[j-1];
			assign s_in    = dvs_q[j-1];
			assign neg_in  = dvneg_q[j-1];
			assign skip_in = dvskip_q[j-1];
		end

		assign den = NUM_W'(s_in) << (Q_W - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= den) begin
						dvrem_q[j][i] <= rem_in[i] - den;
						dvq_q[j][i]   <= q_in[i] | (Q_W'(1) << (Q_W - 1 - j));
					end else begin
						dvrem_q[j][i] <= rem_in[i];
						dvq_q[j][i]   <= q_in[i];
					end
				end
				dvs_q[j]    <= s_in;
				dvneg_q[j]  <= neg_in;
				dvskip_q[j] <= skip_in;
			end
		end
	end

	// restore signs; the quotient never exceeds one in Q1.14
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= dvneg_q[Q_W-1][i] ? -scomp_t'(CW'(dvq_q[Q_W-1][i]))
					: scomp_t'(CW'(dvq_q[Q_W-1][i]));
			end
			skip_q <= dvskip_q[Q_W-1];
		end
	end

	assign n    = n_q;
	assign skip = skip_q;

endmodule

### rtl/obb_obb_separating_axis_test_unit.sv
// Oriented box pair overlap test by separating axes, fully pipelined.
// Takes one box pair per cycle and returns one transaction per pair through 63
// register stages when the output side does not stall. Four stages turn the
// quaternions into face and edge axes. The per-axis normalization lanes take
// 50 stages: two square and sum the candidate, a 32-stage square root and a
// 15-stage divider follow, and one restores the signs. After them four stages
// form the depths, four reduce the 15 candidates and one formats the result.
// The whole pipeline holds while a result waits at the output; empty output
// slots are refilled at once.
module obb_obb_separating_axis_test_unit
	import obbsat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// a_center, a_half, a_orient, b_center, b_half, b_orient (lowest first)
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// min_axis, min_depth (lowest first)
	output logic [OUT_W-1:0] m_axis_tdata,
	// overlap
	output logic             m_axis_tuser
);

	localparam logic signed [M_W-1:0] ONE_Q28 = M_W'(1) <<< 28;
	localparam logic signed [M_W:0]   SAT_HI  = (M_W+1)'((2 ** (CW - 1)) - 1);
	localparam logic signed [M_W:0]   SAT_LO  = -(M_W+1)'(2 ** (CW - 1));

	// quaternion products
	function automatic qprod_t qprod(input logic [ORI_W-1:0] q);
		scomp_t w;
		scomp_t x;
		scomp_t y;
		scomp_t z;
		qprod_t p;
		w = q[0*CW +: CW];
		x = q[1*CW +: CW];
		y = q[2*CW +: CW];
		z = q[3*CW +: CW];
		p.xx = x * x;
		p.yy = y * y;
		p.zz = z * z;
		p.xy = x * y;
		p.xz = x * z;
		p.yz = y * z;
		p.wx = w * x;
		p.wy = w * y;
		p.wz = w * z;
		return p;
	endfunction

	// Q.28 to Q.14, half away from zero, saturated
	function automatic scomp_t round_q14(input logic signed [M_W-1:0] m);
		logic [M_W-1:0]        mag;
		logic [M_W-1:0]        q;
		logic signed [M_W:0]   sq;
		mag = m[M_W-1] ? M_W'(-m) : M_W'(m);
		q   = (mag + (M_W'(1) << (AXIS_SH - 1))) >> AXIS_SH;
		sq  = m[M_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (sq > SAT_HI) sq = SAT_HI;
		if (sq < SAT_LO) sq = SAT_LO;
		return scomp_t'(sq[CW-1:0]);
	endfunction

	// rotation matrix columns as face axes
	function automatic axes_t q_axes(input qprod_t p);
		logic signed [M_W-1:0] m [3][3];
		axes_t ax;
		m[0][0] = ONE_Q28 - ((M_W'(p.yy) + M_W'(p.zz)) <<< 1);
		m[0][1] = (M_W'(p.xy) - M_W'(p.wz)) <<< 1;
		m[0][2] = (M_W'(p.xz) + M_W'(p.wy)) <<< 1;
		m[1][0] = (M_W'(p.xy) + M_W'(p.wz)) <<< 1;
		m[1][1] = ONE_Q28 - ((M_W'(p.xx) + M_W'(p.zz)) <<< 1);
		m[1][2] = (M_W'(p.yz) - M_W'(p.wx)) <<< 1;
		m[2][0] = (M_W'(p.xz) - M_W'(p.wy)) <<< 1;
		m[2][1] = (M_W'(p.yz) + M_W'(p.wx)) <<< 1;
		m[2][2] = ONE_Q28 - ((M_W'(p.xx) + M_W'(p.yy)) <<< 1);
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				ax[k][r] = round_q14(m[r][k]);
			end
		end
		return ax;
	endfunction

	// keep the earlier candidate unless it has none or the later one is strictly shallower
	function automatic cand_t pick(input cand_t l, input cand_t r);
		cand_t o;
		o = l;
		if (!l.have || (r.have && ($signed(r.depth) < $signed(l.depth)))) begin
			o = r;
		end
		o.sep = l.sep | r.sep;
		return o;
	endfunction

	logic en;

	scomp_t a_c [3];
	scomp_t b_c [3];

	qprod_t                 qa_s1, qb_s1;
	logic signed [DC_W-1:0] dc_s1 [3];
	logic [CW-1:0]          ha_s1 [3];
	logic [CW-1:0]          hb_s1 [3];

	axes_t                  axa_s2, axb_s2;
	logic signed [DC_W-1:0] dc_s2 [3];
	logic [CW-1:0]          ha_s2 [3];
	logic [CW-1:0]          hb_s2 [3];

	logic signed [P_W-1:0]  cp_s3 [9][6];
	axes_t                  axa_s3, axb_s3;
	logic signed [DC_W-1:0] dc_s3 [3];
	logic [CW-1:0]          ha_s3 [3];
	logic [CW-1:0]          hb_s3 [3];

	logic signed [V_W-1:0]  v_s4 [N_AX][3];
	box_pair_t              box_s4;

	box_pair_t              box_line_q [LANE_LAT];
	logic [CW-1:0]          ha_d1 [3];
	logic [CW-1:0]          hb_d1 [3];
	logic [CW-1:0]          ha_d2 [3];
	logic [CW-1:0]          hb_d2 [3];

	cand_t cand_d4 [N_LEAF];
	cand_t cand_t1 [8];
	cand_t cand_t2 [4];
	cand_t cand_t3 [2];
	cand_t cand_t4;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic [LANE_LAT-1:0] vline_q;
	logic                vld_d1, vld_d2, vld_d3, vld_d4;
	logic                vld_t1, vld_t2, vld_t3, vld_t4;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic                out_user_q;

	logic [DEP_W-1:0]    dq_sum;
	logic [DEPO_W-1:0]   depth_sat;

	// advance everything unless a result is held at the output
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vline_q     <= '0;
			vld_d1      <= 1'b0;
			vld_d2      <= 1'b0;
			vld_d3      <= 1'b0;
			vld_d4      <= 1'b0;
			vld_t1      <= 1'b0;
			vld_t2      <= 1'b0;
			vld_t3      <= 1'b0;
			vld_t4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= s_axis_tvalid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vline_q     <= {vline_q[LANE_LAT-2:0], vld_s4};
			vld_d1      <= vline_q[LANE_LAT-1];
			vld_d2      <= vld_d1;
			vld_d3      <= vld_d2;
			vld_d4      <= vld_d3;
			vld_t1      <= vld_d4;
			vld_t2      <= vld_t1;
			vld_t3      <= vld_t2;
			vld_t4      <= vld_t3;
			out_valid_q <= vld_t4;
		end
	end

	// unpack centers
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = s_axis_tdata[A_CEN_LSB + i*CW +: CW];
			b_c[i] = s_axis_tdata[B_CEN_LSB + i*CW +: CW];
		end
	end

	// stage 1: quaternion products, center offset
	always_ff @(posedge clk) begin
		if (en) begin
			qa_s1 <= qprod(s_axis_tdata[A_ORI_LSB +: ORI_W]);
			qb_s1 <= qprod(s_axis_tdata[B_ORI_LSB +: ORI_W]);
			for (int i = 0; i < 3; i++) begin
				dc_s1[i] <= DC_W'(b_c[i]) - DC_W'(a_c[i]);
				ha_s1[i] <= s_axis_tdata[A_HLF_LSB + i*CW +: CW];
				hb_s1[i] <= s_axis_tdata[B_HLF_LSB + i*CW +: CW];
			end
		end
	end

	// stage 2: face axes
	always_ff @(posedge clk) begin
		if (en) begin
			axa_s2 <= q_axes(qa_s1);
			axb_s2 <= q_axes(qb_s1);
			dc_s2  <= dc_s1;
			ha_s2  <= ha_s1;
			hb_s2  <= hb_s1;
		end
	end

	// stage 3: edge cross product terms, A axis outer, B axis inner
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cp_s3[i*3+j][0] <= axa_s2[i][1] * axb_s2[j][2];
					cp_s3[i*3+j][1] <= axa_s2[i][2] * axb_s2[j][1];
					cp_s3[i*3+j][2] <= axa_s2[i][2] * axb_s2[j][0];
					cp_s3[i*3+j][3] <= axa_s2[i][0] * axb_s2[j][2];
					cp_s3[i*3+j][4] <= axa_s2[i][0] * axb_s2[j][1];
					cp_s3[i*3+j][5] <= axa_s2[i][1] * axb_s2[j][0];
				end
			end
			axa_s3 <= axa_s2;
			axb_s3 <= axb_s2;
			dc_s3  <= dc_s2;
			ha_s3  <= ha_s2;
			hb_s3  <= hb_s2;
		end
	end

	// stage 4: all fifteen candidates in Q.28
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					v_s4[k][i]   <= V_W'(axa_s3[k][i]) <<< AXIS_SH;
					v_s4[3+k][i] <= V_W'(axb_s3[k][i]) <<< AXIS_SH;
				end
			end
			for (int c = 0; c < 9; c++) begin
				v_s4[6+c][0] <= V_W'(cp_s3[c][0]) - V_W'(cp_s3[c][1]);
				v_s4[6+c][1] <= V_W'(cp_s3[c][2]) - V_W'(cp_s3[c][3]);
				v_s4[6+c][2] <= V_W'(cp_s3[c][4]) - V_W'(cp_s3[c][5]);
			end
			box_s4.ax_a <= axa_s3;
			box_s4.ax_b <= axb_s3;
			box_s4.dc   <= dc_s3;
			box_s4.ha   <= ha_s3;
			box_s4.hb   <= hb_s3;
		end
	end

	// delay the box data alongside the normalization lanes
	always_ff @(posedge clk) begin
		if (en) begin
			box_line_q[0] <= box_s4;
			for (int k = 1; k < LANE_LAT; k++) begin
				box_line_q[k] <= box_line_q[k-1];
			end
			ha_d1 <= box_line_q[LANE_LAT-1].ha;
			hb_d1 <= box_line_q[LANE_LAT-1].hb;
			ha_d2 <= ha_d1;
			hb_d2 <= hb_d1;
		end
	end

	// one lane per candidate axis
	for (genvar l = 0; l < N_AX; l++) begin : g_lane
		scomp_t                   nl [3];
		logic                     skl;
		logic signed [P_W-1:0]    pa_d1 [3][3];
		logic signed [P_W-1:0]    pb_d1 [3][3];
		logic signed [PD_W-1:0]   pd_d1 [3];
		scomp_t                   n_d1 [3];
		logic                     skip_d1;
		logic signed [DOT_W-1:0]  dota [3];
		logic signed [DOT_W-1:0]  dotb [3];
		logic signed [DIST_W-1:0] cdist;
		logic [AD_W-1:0]          ada_d2 [3];
		logic [AD_W-1:0]          adb_d2 [3];
		logic [ADIST_W-1:0]       adist_d2;
		scomp_t                   n_d2 [3];
		logic                     skip_d2;
		logic [RP_W-1:0]          rpa_d3 [3];
		logic [RP_W-1:0]          rpb_d3 [3];
		logic [DQ_W-1:0]          distq_d3;
		scomp_t                   n_d3 [3];
		logic                     skip_d3;
		logic [DEP_W-1:0]         tot;
		logic [DEP_W-1:0]         depth_d4;
		scomp_t                   n_d4 [3];
		logic                     skip_d4;

		obbsat_norm u_norm (
			.clk  (clk),
			.en   (en),
			.v    (v_s4[l]),
			.n    (nl),
			.skip (skl)
		);

		// projections of the face axes and the center offset
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					for (int i = 0; i < 3; i++) begin
						pa_d1[k][i] <= box_line_q[LANE_LAT-1].ax_a[k][i] * nl[i];
						pb_d1[k][i] <= box_line_q[LANE_LAT-1].ax_b[k][i] * nl[i];
					end
				end
				for (int i = 0; i < 3; i++) begin
					pd_d1[i] <= box_line_q[LANE_LAT-1].dc[i] * nl[i];
				end
				n_d1    <= nl;
				skip_d1 <= skl;
			end
		end

		// dot products and their magnitudes
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				dota[k] = DOT_W'(pa_d1[k][0]) + DOT_W'(pa_d1[k][1]) + DOT_W'(pa_d1[k][2]);
				dotb[k] = DOT_W'(pb_d1[k][0]) + DOT_W'(pb_d1[k][1]) + DOT_W'(pb_d1[k][2]);
			end
			cdist = DIST_W'(pd_d1[0]) + DIST_W'(pd_d1[1]) + DIST_W'(pd_d1[2]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					ada_d2[k] <= dota[k][DOT_W-1] ? AD_W'(-dota[k]) : AD_W'(dota[k]);
					adb_d2[k] <= dotb[k][DOT_W-1] ? AD_W'(-dotb[k]) : AD_W'(dotb[k]);
				end
				adist_d2 <= cdist[DIST_W-1] ? ADIST_W'(-cdist) : ADIST_W'(cdist);
				n_d2     <= n_d1;
				skip_d2  <= skip_d1;
			end
		end

		// radius terms in Q.36
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					rpa_d3[k] <= ada_d2[k] * ha_d2[k];
					rpb_d3[k] <= adb_d2[k] * hb_d2[k];
				end
				distq_d3 <= {adist_d2, {AXIS_SH{1'b0}}};
				n_d3     <= n_d2;
				skip_d3  <= skip_d2;
			end
		end

		// penetration depth, negative when separated on this axis
		assign tot = DEP_W'(rpa_d3[0]) + DEP_W'(rpa_d3[1]) + DEP_W'(rpa_d3[2])
			+ DEP_W'(rpb_d3[0]) + DEP_W'(rpb_d3[1]) + DEP_W'(rpb_d3[2])
			- DEP_W'(distq_d3);

		always_ff @(posedge clk) begin
			if (en) begin
				depth_d4 <= tot;
				n_d4     <= n_d3;
				skip_d4  <= skip_d3;
			end
		end

		assign cand_d4[l].have  = !skip_d4;
		assign cand_d4[l].sep   = !skip_d4 && depth_d4[DEP_W-1];
		assign cand_d4[l].depth = depth_d4;
		assign cand_d4[l].n     = {n_d4[2], n_d4[1], n_d4[0]};
	end

	// pad leaf of the reduction tree
	assign cand_d4[N_AX] = '0;

	// reduce the candidates, earlier axes on the left
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				cand_t1[i] <= pick(cand_d4[2*i], cand_d4[2*i+1]);
			end
			for (int i = 0; i < 4; i++) begin
				cand_t2[i] <= pick(cand_t1[2*i], cand_t1[2*i+1]);
			end
			for (int i = 0; i < 2; i++) begin
				cand_t3[i] <= pick(cand_t2[2*i], cand_t2[2*i+1]);
			end
			cand_t4 <= pick(cand_t3[0], cand_t3[1]);
		end
	end

	// round the depth to Q16.8 and saturate
	assign dq_sum    = cand_t4.depth + (DEP_W'(1) << 27);
	assign depth_sat = (|dq_sum[DEP_W-1:28+DEPO_W]) ? DEPTH_MAX : dq_sum[28 +: DEPO_W];

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_user_q <= !cand_t4.sep;
			if (cand_t4.sep) begin
				out_data_q <= '0;
			end else if (!cand_t4.have) begin
				out_data_q <= {DEPTH_MAX, {AXO_W{1'b0}}};
			end else begin
				out_data_q <= {depth_sat, cand_t4.n};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

### rtl/obbsat_checker.sv
// Port-level checker for the box overlap test unit, bound to the top level
`include "obb_obb_separating_axis_test_unit_macros.svh"

module obbsat_checker
	import obbsat_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tuser
);

	// a held result keeps its payload
	`OBBSAT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output transaction changed while stalled")

	// separation reports zero axis and depth
	`OBBSAT_ASSERT_IMPLY(a_sep_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "separated result carries payload")

	// overlap with no usable axis reports full depth
	`OBBSAT_ASSERT_IMPLY(a_degen_depth, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[AXO_W-1:0] == '0), m_axis_tdata[OUT_W-1:AXO_W] == DEPTH_MAX, "zero axis without saturated depth")

	// input stalls only behind a held output
	`OBBSAT_ASSERT_IMPLY(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

endmodule

bind obb_obb_separating_axis_test_unit obbsat_checker u_obbsat_checker (.*);
